/* sv/uvs_pkg.sv */
package uvs_pkg;

   localparam int BYTE_W       = 8;
   localparam int LIKELIHOOD_W = 17;
   localparam int PENDING_W    = 2;

   typedef logic [BYTE_W-1:0]    byte_type;
   typedef logic [PENDING_W-1:0] pending_type;

   localparam byte_type BYTE_NUL   = 8'h00;
   localparam byte_type BYTE_ASCII_LIMIT = 8'h80;
   localparam byte_type LEAD2_LO   = 8'hC2;
   localparam byte_type LEAD2_HI   = 8'hDF;
   localparam byte_type LEAD3_LO   = 8'hE0;
   localparam byte_type LEAD3_HI   = 8'hEF;
   localparam byte_type LEAD3_E0   = 8'hE0;
   localparam byte_type LEAD3_ED   = 8'hED;
   localparam byte_type LEAD3_RARE_LO = 8'hEA;
   localparam byte_type LEAD3_RARE_HI = 8'hEE;
   localparam byte_type LEAD4_LO   = 8'hF0;
   localparam byte_type LEAD4_HI   = 8'hF4;
   localparam byte_type CONT_LO    = 8'h80;
   localparam byte_type CONT_HI    = 8'hBF;
   localparam byte_type CONT_E0_LO = 8'hA0;
   localparam byte_type CONT_ED_HI = 8'h9F;
   localparam byte_type CONT_F0_LO = 8'h90;
   localparam byte_type CONT_F4_HI = 8'h8F;

   localparam pending_type PEND_NONE  = 2'd0;
   localparam pending_type PEND_ONE   = 2'd1;
   localparam pending_type PEND_TWO   = 2'd2;
   localparam pending_type PEND_THREE = 2'd3;

endpackage

/* sv/uvs_if.sv */
interface uvs_req_if
   import uvs_pkg::*;
   ();
   logic     valid;
   logic     ready;
   byte_type byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

interface uvs_rsp_if
   import uvs_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic                    accepted;
   logic [LIKELIHOOD_W-1:0] likelihood;
   pending_type             pending;

   modport source (output valid, output accepted, output likelihood, output pending,
                   input ready);
   modport sink   (input valid, input accepted, input likelihood, input pending,
                   output ready);
endinterface

/* sv/utf8_validator_scorer.sv */
// Channel    Role     Payload                                Handshake
// req_chan   sink     byte_in[7:0]                           valid/ready
// rsp_chan   source   accepted, likelihood[16:0], pending    valid/ready
//
// One byte per cycle sustained while results are taken; each beat passes
// through the input register and then the result register, which drives the
// outputs. The limit is the single score multiplier between the two registers.
// Reset is synchronous and clears the sequence state and the score to 1.0. A
// stalled result holds both stages; the input register still takes a beat
// while it is empty and only the result waits.
module utf8_validator_scorer
   import uvs_pkg::*;
   #(
   parameter int SCORE_FRAC_BITS = 16
   )
   (
   input logic      clock,
   input logic      reset,
   uvs_req_if.sink   req_chan,
   uvs_rsp_if.source rsp_chan
   );

   localparam int SCORE_W = SCORE_FRAC_BITS + 1;
   localparam logic [63:0] FACTOR_0P9_WIDE = ((64'd9 << SCORE_FRAC_BITS) + 64'd5) / 64'd10;
   localparam logic [63:0] FACTOR_0P8_WIDE = ((64'd8 << SCORE_FRAC_BITS) + 64'd5) / 64'd10;
   localparam logic [SCORE_FRAC_BITS-1:0] FACTOR_0P9 = FACTOR_0P9_WIDE[SCORE_FRAC_BITS-1:0];
   localparam logic [SCORE_FRAC_BITS-1:0] FACTOR_0P8 = FACTOR_0P8_WIDE[SCORE_FRAC_BITS-1:0];
   localparam logic [SCORE_W-1:0] SCORE_ONE = {1'b1, {SCORE_FRAC_BITS{1'b0}}};

   logic         in_valid_ff;
   byte_type     byte_ff;
   logic         rsp_valid_ff;
   logic         accepted_ff;
   logic [SCORE_W-1:0] likelihood_ff;
   pending_type  pending_ff;

   pending_type  remaining_ff, remaining_in;
   byte_type     low_bound_ff, low_bound_in;
   byte_type     high_bound_ff, high_bound_in;
   logic [SCORE_W-1:0] score_ff, score_in;

   logic         advance;
   logic         ok;
   logic         scale;
   logic         use_0p9;
   logic [SCORE_FRAC_BITS-1:0] factor;
   logic [SCORE_W+SCORE_FRAC_BITS-1:0] product;
   logic [SCORE_W+LIKELIHOOD_W-1:0]    likelihood_wide;

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      ok            = 1'b1;
      scale         = 1'b0;
      use_0p9       = 1'b0;
      remaining_in  = remaining_ff;
      low_bound_in  = low_bound_ff;
      high_bound_in = high_bound_ff;
      if (remaining_ff == PEND_NONE) begin
         if (byte_ff >= LEAD2_LO && byte_ff <= LEAD2_HI) begin
            remaining_in  = PEND_ONE;
            low_bound_in  = CONT_LO;
            high_bound_in = CONT_HI;
            scale         = 1'b1;
            use_0p9       = 1'b1;
         end else if (byte_ff >= LEAD3_LO && byte_ff <= LEAD3_HI) begin
            remaining_in  = PEND_TWO;
            low_bound_in  = (byte_ff == LEAD3_E0) ? CONT_E0_LO : CONT_LO;
            high_bound_in = (byte_ff == LEAD3_ED) ? CONT_ED_HI : CONT_HI;
            scale         = (byte_ff >= LEAD3_RARE_LO) && (byte_ff <= LEAD3_RARE_HI);
         end else if (byte_ff >= LEAD4_LO && byte_ff <= LEAD4_HI) begin
            remaining_in  = PEND_THREE;
            low_bound_in  = (byte_ff == LEAD4_LO) ? CONT_F0_LO : CONT_LO;
            high_bound_in = (byte_ff == LEAD4_HI) ? CONT_F4_HI : CONT_HI;
            scale         = 1'b1;
         end else if (byte_ff >= BYTE_ASCII_LIMIT) begin
            ok = 1'b0;
         end else if (byte_ff == BYTE_NUL) begin
            scale = 1'b1;
         end
      end else begin
         if (byte_ff < low_bound_ff || byte_ff > high_bound_ff) begin
            ok = 1'b0;
         end else begin
            remaining_in  = remaining_ff - PEND_ONE;
            low_bound_in  = CONT_LO;
            high_bound_in = CONT_HI;
         end
      end
   end

   assign factor   = use_0p9 ? FACTOR_0P9 : FACTOR_0P8;
   assign product  = {{SCORE_FRAC_BITS{1'b0}}, score_ff} *
                     {{SCORE_W{1'b0}}, factor};
   assign score_in = scale ? product[SCORE_W+SCORE_FRAC_BITS-1:SCORE_FRAC_BITS] : score_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         remaining_ff  <= PEND_NONE;
         low_bound_ff  <= CONT_LO;
         high_bound_ff <= CONT_HI;
         score_ff      <= SCORE_ONE;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff  <= 1'b1;
            remaining_ff  <= remaining_in;
            low_bound_ff  <= low_bound_in;
            high_bound_ff <= high_bound_in;
            score_ff      <= score_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         byte_ff <= req_chan.byte_in;
      end
      if (advance) begin
         accepted_ff   <= ok;
         likelihood_ff <= score_in;
         pending_ff    <= remaining_in;
      end
   end

   assign likelihood_wide     = {{LIKELIHOOD_W{1'b0}}, likelihood_ff};
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.accepted   = accepted_ff;
   assign rsp_chan.likelihood = likelihood_wide[LIKELIHOOD_W-1:0];
   assign rsp_chan.pending    = pending_ff;

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid after reset");

   a_score_never_grows: assert property (@(posedge clock) disable iff (reset)
      advance |-> (score_in <= score_ff))
      else $error("score increased");

   a_rejected_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (advance && !ok) |=> (remaining_ff == $past(remaining_ff)
                            && score_ff == $past(score_ff)))
      else $error("rejected beat changed state");

   a_bounds_in_cont_range: assert property (@(posedge clock) disable iff (reset)
      (remaining_ff != PEND_NONE) |-> (low_bound_ff >= CONT_LO
                                        && high_bound_ff <= CONT_HI
                                        && low_bound_ff <= high_bound_ff))
      else $error("continuation bounds out of range");

endmodule
